// File: src/jsu_pkg.sv
// shared types and constants of the json string unescaper
// no dependencies
`default_nettype none

package jsu_pkg;

    localparam int unsigned MaxRes = 4;

    // result kinds
    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_END  = 2'd1;
    localparam logic [1:0] KIND_ERR  = 2'd2;

    // error codes
    localparam logic [2:0] ERR_MISSING_QUOTE = 3'd0;
    localparam logic [2:0] ERR_BAD_CHAR      = 3'd1;
    localparam logic [2:0] ERR_BAD_ESCAPE    = 3'd2;
    localparam logic [2:0] ERR_BAD_HEX       = 3'd3;
    localparam logic [2:0] ERR_BAD_SURR      = 3'd4;

    // characters
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_U     = 8'h75;

    // group of results caused by one input item
    typedef struct packed {
        logic [MaxRes-1:0][7:0] bytes;
        logic [2:0]             cnt;
        logic [1:0]             kind;
        logic [2:0]             err;
    } t_grp;

endpackage

`default_nettype wire

// File: src/jsu_if.sv
// valid/ready channel interfaces for input bytes and result items
// no dependencies
`default_nettype none

interface jsu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface jsu_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [1:0] kind;
    logic [2:0] error_code;
    logic       last;

    modport source (output valid, output out_byte, output kind, output error_code,
                    output last, input ready);
    modport sink   (input valid, input out_byte, input kind, input error_code,
                    input last, output ready);
endinterface

`default_nettype wire

// File: src/jsu_decode.sv
// escape state machine and utf-8 encoder: one input byte to a group of results
// depends on jsu_pkg
`default_nettype none

module jsu_decode
    import jsu_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_accept,
    input  wire logic [7:0] i_byte,
    output t_grp            o_grp
);

    typedef enum logic [5:0] {
        PH_PLAIN   = 6'b000001,
        PH_ESC     = 6'b000010,
        PH_HEX     = 6'b000100,
        PH_WANT_BS = 6'b001000,
        PH_WANT_U  = 6'b010000,
        PH_LOW     = 6'b100000
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [1:0]  r_dig, n_dig;
    logic [15:0] r_acc, n_acc;
    logic [9:0]  r_high, n_high;

    logic        hex_ok;
    logic [3:0]  hex_val;
    logic [15:0] acc_next;
    logic [20:0] cp_pair;

    function automatic t_grp enc_utf8(input logic [20:0] u);
        t_grp g;
        g = '0;
        g.kind = KIND_DATA;
        g.err  = ERR_MISSING_QUOTE;
        if (u <= 21'h7F) begin
            g.bytes[0] = u[7:0];
            g.cnt      = 3'd1;
        end else if (u <= 21'h7FF) begin
            g.bytes[0] = 8'hC0 | {3'b000, u[10:6]};
            g.bytes[1] = 8'h80 | {2'b00, u[5:0]};
            g.cnt      = 3'd2;
        end else if (u <= 21'hFFFF) begin
            g.bytes[0] = 8'hE0 | {4'b0000, u[15:12]};
            g.bytes[1] = 8'h80 | {2'b00, u[11:6]};
            g.bytes[2] = 8'h80 | {2'b00, u[5:0]};
            g.cnt      = 3'd3;
        end else begin
            g.bytes[0] = 8'hF0 | {5'b00000, u[20:18]};
            g.bytes[1] = 8'h80 | {2'b00, u[17:12]};
            g.bytes[2] = 8'h80 | {2'b00, u[11:6]};
            g.bytes[3] = 8'h80 | {2'b00, u[5:0]};
            g.cnt      = 3'd4;
        end
        return g;
    endfunction

    function automatic t_grp one_res(input logic [7:0] b, input logic [1:0] k,
                                     input logic [2:0] e);
        t_grp g;
        g = '0;
        g.bytes[0] = b;
        g.cnt      = 3'd1;
        g.kind     = k;
        g.err      = e;
        return g;
    endfunction

    // hex digit decode
    always_comb begin
        hex_ok  = 1'b1;
        hex_val = 4'd0;
        if (i_byte >= 8'h30 && i_byte <= 8'h39) begin
            hex_val = 4'(i_byte - 8'h30);
        end else if (i_byte >= 8'h41 && i_byte <= 8'h46) begin
            hex_val = 4'(i_byte - 8'h37);
        end else if (i_byte >= 8'h61 && i_byte <= 8'h66) begin
            hex_val = 4'(i_byte - 8'h57);
        end else begin
            hex_ok = 1'b0;
        end
    end

    assign acc_next = {r_acc[11:0], hex_val};
    // surrogate pair: 0x10000 + (high << 10) + low bits
    assign cp_pair  = 21'h10000 + {1'b0, r_high, acc_next[9:0]};

    always_comb begin
        n_phase = r_phase;
        n_dig   = r_dig;
        n_acc   = r_acc;
        n_high  = r_high;
        o_grp   = '0;
        case (r_phase)
            PH_ESC: begin
                n_phase = PH_PLAIN;
                case (i_byte)
                    8'h22: o_grp = one_res(8'h22, KIND_DATA, ERR_MISSING_QUOTE);
                    8'h5C: o_grp = one_res(8'h5C, KIND_DATA, ERR_MISSING_QUOTE);
                    8'h2F: o_grp = one_res(8'h2F, KIND_DATA, ERR_MISSING_QUOTE);
                    8'h62: o_grp = one_res(8'h08, KIND_DATA, ERR_MISSING_QUOTE);
                    8'h66: o_grp = one_res(8'h0C, KIND_DATA, ERR_MISSING_QUOTE);
                    8'h6E: o_grp = one_res(8'h0A, KIND_DATA, ERR_MISSING_QUOTE);
                    8'h72: o_grp = one_res(8'h0D, KIND_DATA, ERR_MISSING_QUOTE);
                    8'h74: o_grp = one_res(8'h09, KIND_DATA, ERR_MISSING_QUOTE);
                    8'h75: begin
                        n_phase = PH_HEX;
                        n_dig   = 2'd0;
                        n_acc   = '0;
                    end
                    default: o_grp = one_res(8'h00, KIND_ERR, ERR_BAD_ESCAPE);
                endcase
            end
            PH_HEX: begin
                if (!hex_ok) begin
                    o_grp   = one_res(8'h00, KIND_ERR, ERR_BAD_HEX);
                    n_phase = PH_PLAIN;
                end else begin
                    n_acc = acc_next;
                    if (r_dig != 2'd3) begin
                        n_dig = r_dig + 2'd1;
                    end else if (acc_next >= 16'hD800 && acc_next <= 16'hDBFF) begin
                        n_high  = acc_next[9:0];
                        n_phase = PH_WANT_BS;
                    end else begin
                        o_grp   = enc_utf8({5'b00000, acc_next});
                        n_phase = PH_PLAIN;
                    end
                end
            end
            PH_WANT_BS: begin
                if (i_byte != CH_BSL) begin
                    o_grp   = one_res(8'h00, KIND_ERR, ERR_BAD_SURR);
                    n_phase = PH_PLAIN;
                end else begin
                    n_phase = PH_WANT_U;
                end
            end
            PH_WANT_U: begin
                if (i_byte != CH_U) begin
                    o_grp   = one_res(8'h00, KIND_ERR, ERR_BAD_SURR);
                    n_phase = PH_PLAIN;
                end else begin
                    n_phase = PH_LOW;
                    n_dig   = 2'd0;
                    n_acc   = '0;
                end
            end
            PH_LOW: begin
                if (!hex_ok) begin
                    o_grp   = one_res(8'h00, KIND_ERR, ERR_BAD_SURR);
                    n_phase = PH_PLAIN;
                end else begin
                    n_acc = acc_next;
                    if (r_dig != 2'd3) begin
                        n_dig = r_dig + 2'd1;
                    end else if (acc_next[15:10] != 6'b110111) begin
                        o_grp   = one_res(8'h00, KIND_ERR, ERR_BAD_SURR);
                        n_phase = PH_PLAIN;
                    end else begin
                        o_grp   = enc_utf8(cp_pair);
                        n_phase = PH_PLAIN;
                    end
                end
            end
            default: begin
                // plain text
                n_phase = PH_PLAIN;
                if (i_byte == CH_QUOTE) begin
                    o_grp = one_res(8'h00, KIND_END, ERR_MISSING_QUOTE);
                end else if (i_byte == CH_BSL) begin
                    n_phase = PH_ESC;
                end else if (i_byte == CH_NUL) begin
                    o_grp = one_res(8'h00, KIND_ERR, ERR_MISSING_QUOTE);
                end else if (i_byte < CH_SPACE) begin
                    o_grp = one_res(8'h00, KIND_ERR, ERR_BAD_CHAR);
                end else begin
                    o_grp = one_res(i_byte, KIND_DATA, ERR_MISSING_QUOTE);
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_PLAIN;
            r_dig   <= 2'd0;
            r_acc   <= '0;
            r_high  <= '0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_dig   <= n_dig;
            r_acc   <= n_acc;
            r_high  <= n_high;
        end
    end

endmodule

`default_nettype wire

// File: src/json_string_unescape_utf8_core.sv
// json string body unescaper with utf-8 output: top level
// depends on jsu_pkg, jsu_if and jsu_decode
//
// usage:
//   i_in carries raw bytes of a json string body, starting after the opening
//   quote. o_out carries result items: decoded utf-8 data bytes, a string-end
//   marker on the closing quote, or an error. last marks the final item
//   caused by one input byte.
//   an input byte is decoded in the cycle it is accepted and its results
//   (0 to 4 items) sit in the result register from the next cycle on.
//   throughput: one byte per cycle while each byte gives at most one result
//   and the receiver is ready; a byte with n results holds the input until
//   its last result is taken, as the result register drains one item per
//   cycle on the output port while the receiver is ready. bytes with no result
//   (opening backslash, u, hex digits ending no character) leave input free.
//   the next byte is taken in the same cycle the last queued item leaves.
//   reset (synchronous, active low) returns to plain text and empties the
//   result register. a stalled receiver holds the current item stable;
//   input is taken again once the last pending item is accepted.
`default_nettype none

module json_string_unescape_utf8_core
    import jsu_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    jsu_in_if.sink     i_in,
    jsu_out_if.source  o_out
);

    t_grp       grp;
    t_grp       r_grp;
    logic [2:0] r_cnt;
    logic [1:0] r_idx;
    logic       accept;
    logic       out_fire;

    assign out_fire   = o_out.valid && o_out.ready;
    // free when empty or when the last pending item leaves now
    assign i_in.ready = (r_cnt == 3'd0) || (r_cnt == 3'd1 && o_out.ready);
    assign accept     = i_in.valid && i_in.ready;

    jsu_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_accept(accept),
        .i_byte  (i_in.in_byte),
        .o_grp   (grp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 3'd0;
            r_idx <= 2'd0;
        end else if (accept) begin
            r_cnt <= grp.cnt;
            r_idx <= 2'd0;
        end else if (out_fire) begin
            r_cnt <= r_cnt - 3'd1;
            r_idx <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_grp <= grp;
        end
    end

    assign o_out.valid      = (r_cnt != 3'd0);
    assign o_out.out_byte   = r_grp.bytes[r_idx];
    assign o_out.kind       = r_grp.kind;
    assign o_out.error_code = r_grp.err;
    assign o_out.last       = (r_cnt == 3'd1);

endmodule

`default_nettype wire

// File: src/jsu_checker.sv
// port-level checks on the result channel of the unescaper, bound to the top level
// depends on jsu_pkg
`default_nettype none

module jsu_checker
    import jsu_pkg::*;
(
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_valid,
    input wire logic       i_ready,
    input wire logic [7:0] i_out_byte,
    input wire logic [1:0] i_kind,
    input wire logic [2:0] i_error_code,
    input wire logic       i_last
);

    // end and error items always stand alone
    a_ctl_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_kind != KIND_DATA) |-> i_last)
        else $error("end or error item without last");

    a_ctl_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_kind != KIND_DATA) |-> (i_out_byte == 8'h00))
        else $error("nonzero byte on end or error item");

    a_err_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_kind != KIND_ERR) |-> (i_error_code == ERR_MISSING_QUOTE))
        else $error("error code set on non-error item");

    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !i_ready) |=> (i_valid && $stable(i_out_byte) && $stable(i_last)))
        else $error("item changed under stall");

endmodule

bind json_string_unescape_utf8_core jsu_checker u_jsu_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (o_out.valid),
    .i_ready     (o_out.ready),
    .i_out_byte  (o_out.out_byte),
    .i_kind      (o_out.kind),
    .i_error_code(o_out.error_code),
    .i_last      (o_out.last)
);

`default_nettype wire
